@@ rtl/core/assert_macros.svh @@
// assert_macros.svh: assertion macros for the rtl
// depends on nothing; taken in by files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define LBP_ASSERT(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in this cycle
`define LBP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define LBP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lbp_pkg.sv @@
// lbp_pkg: types, codes and the pattern function of the lbp code histogram
// depends on nothing; used by lbp_code_histogram_top, the checker and the testbench
`default_nettype none

package lbp_pkg;

   localparam int PIX_W      = 8;
   localparam int CODE_W     = 8;
   localparam int ROW_W      = 11;
   localparam int BINS       = 256;
   localparam int OUT_CNT_W  = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   // smallest legal image size and the row cap
   localparam logic [CSR_DATA_W-1:0] SIZE_MIN   = 12'd3;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_CAP = 12'd2048;

   // reset sizes
   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = 12'd480;

   // operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   typedef struct packed {
      logic              operation;
      logic [PIX_W-1:0]  pixel;
      logic [CODE_W-1:0] bin_select;
   } req_item_type;

   typedef struct packed {
      logic [CODE_W-1:0]    bin_index;
      logic [OUT_CNT_W-1:0] bin_count;
   } rsp_item_type;

   // neighbours ordered by weight bit: top left, top, top right, right,
   // bottom right, bottom, bottom left, left
   typedef logic [7:0][PIX_W-1:0] nbr_type;

   // one bit per neighbour that is at least the centre
   function automatic logic [CODE_W-1:0] lbp_code(input nbr_type nbr,
                                                  input logic [PIX_W-1:0] centre);
      logic [CODE_W-1:0] code;
      for (int i = 0; i < 8; i++) begin
         code[i] = (nbr[i] >= centre);
      end
      return code;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/lbp_code_histogram_top.sv @@
// lbp_code_histogram_top: 3x3 local binary pattern codes over a raster pixel stream
// depends on lbp_pkg, lbp_ram and assert_macros.svh
//
//   port group   direction   moves
//   req_*        in          one item: push a pixel or read-and-clear a bin
//   rsp_*        out         one item per read: bin index and its count
//   csr_*        in          write of image_width or image_height
//
// one item is taken every cycle while req_stall is low; a read passes through
// stage 1 (histogram ram read), stage 2 (modify and write back) and rsp_item_ff.
// line buffers sit in one ram of two pixels per column, read one stage ahead.
// reset clears counters, window, output and the histogram valid bits at once:
// no clearing pass, the first item may follow reset directly.
// req_stall rises only while a read result waits under rsp_stall and another read
// has reached the last stage; the whole pipeline then holds.
`default_nettype none
`include "assert_macros.svh"

module lbp_code_histogram_top #(
   parameter int MAX_WIDTH  = 2048,
   parameter int COUNT_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire lbp_pkg::req_item_type         req_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output lbp_pkg::rsp_item_type              rsp_item,
   input  wire logic                          csr_write,
   input  wire logic [lbp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lbp_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CMP_W  = 14;
   localparam int BIN_AW = $clog2(lbp_pkg::BINS);
   localparam int PW     = lbp_pkg::PIX_W;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // configuration registers
   logic [lbp_pkg::CSR_DATA_W-1:0] width_ff, width_in;
   logic [lbp_pkg::CSR_DATA_W-1:0] height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            lbp_pkg::REG_IMAGE_WIDTH:  width_in  = csr_data;
            lbp_pkg::REG_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lbp_pkg::WIDTH_RESET;
         height_ff <= lbp_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // clamped sizes, as last column and last row
   logic [CMP_W-1:0]                 w_raw, w_eff;
   logic [lbp_pkg::CSR_DATA_W-1:0]   h_eff;
   logic [COL_W-1:0]                 col_last;
   logic [lbp_pkg::ROW_W-1:0]        row_last;

   always_comb begin
      w_raw = CMP_W'(width_ff);
      if (w_raw < CMP_W'(lbp_pkg::SIZE_MIN)) begin
         w_eff = CMP_W'(lbp_pkg::SIZE_MIN);
      end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      if (height_ff < lbp_pkg::SIZE_MIN) begin
         h_eff = lbp_pkg::SIZE_MIN;
      end else if (height_ff > lbp_pkg::HEIGHT_CAP) begin
         h_eff = lbp_pkg::HEIGHT_CAP;
      end else begin
         h_eff = height_ff;
      end
      col_last = COL_W'(w_eff - CMP_W'(1));
      row_last = lbp_pkg::ROW_W'(h_eff - lbp_pkg::CSR_DATA_W'(1));
   end

   // pipeline advance: holds only when a read result cannot leave
   logic adv;
   logic accept;
   logic s2_valid_ff, s2_read_ff;

   assign adv       = !(rsp_valid && rsp_stall && s2_valid_ff && s2_read_ff);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   // raster position
   logic [COL_W-1:0]          col_ff, col_in;
   logic [lbp_pkg::ROW_W-1:0] row_ff, row_in;
   logic                      push_acc;

   assign push_acc = accept && (req_item.operation == lbp_pkg::OP_PUSH);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (push_acc) begin
         if (col_ff >= col_last) begin
            col_in = '0;
            row_in = (row_ff >= row_last) ? '0 : row_ff + lbp_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1 registers: item fields while the line buffers are read
   logic                      s1_valid_ff;
   logic                      s1_read_ff;
   logic [PW-1:0]             s1_pixel_ff;
   logic [lbp_pkg::CODE_W-1:0] s1_bin_ff;
   logic [COL_W-1:0]          s1_col_ff;
   logic                      s1_inner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_read_ff  <= (req_item.operation == lbp_pkg::OP_READ);
         s1_pixel_ff <= req_item.pixel;
         s1_bin_ff   <= req_item.bin_select;
         s1_col_ff   <= col_ff;
         s1_inner_ff <= (row_ff >= lbp_pkg::ROW_W'(2)) && (col_ff >= COL_W'(2));
      end
   end

   // line buffers: one word per column, two rows back in the upper byte
   logic              lb_wr_en;
   logic [2*PW-1:0]   lb_rd_data;
   logic [PW-1:0]     top_px, mid_px;
   logic              s1_push;

   assign s1_push  = s1_valid_ff && !s1_read_ff;
   assign top_px   = lb_rd_data[2*PW-1:PW];
   assign mid_px   = lb_rd_data[PW-1:0];
   assign lb_wr_en = adv && s1_push;

   lbp_ram #(
      .WIDTH (2*PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (lb_wr_en),
      .wr_addr (s1_col_ff),
      .wr_data ({mid_px, s1_pixel_ff}),
      .rd_en   (adv),
      .rd_addr (col_ff),
      .rd_data (lb_rd_data)
   );

   // window: the two newest columns, top, middle, bottom
   logic [2:0][PW-1:0] win_c1_ff, win_c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_c1_ff <= '0;
         win_c2_ff <= '0;
      end else if (lb_wr_en) begin
         win_c1_ff <= win_c2_ff;
         win_c2_ff <= {s1_pixel_ff, mid_px, top_px};
      end
   end

   // pattern code of the window after this shift
   lbp_pkg::nbr_type           nbr;
   logic [lbp_pkg::CODE_W-1:0] code;

   always_comb begin
      nbr[0] = win_c1_ff[0];   // top left
      nbr[1] = win_c2_ff[0];   // top
      nbr[2] = top_px;         // top right
      nbr[3] = mid_px;         // right
      nbr[4] = s1_pixel_ff;    // bottom right
      nbr[5] = win_c2_ff[2];   // bottom
      nbr[6] = win_c1_ff[2];   // bottom left
      nbr[7] = win_c1_ff[1];   // left
      code   = lbp_pkg::lbp_code(nbr, win_c2_ff[1]);
   end

   // stage 2 registers: histogram read-modify-write
   logic                       s2_inc_ff;
   logic [BIN_AW-1:0]          s2_addr_ff;
   logic [BIN_AW-1:0]          hist_rd_addr;

   assign hist_rd_addr = s1_read_ff ? s1_bin_ff : code;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && (s1_read_ff || s1_inner_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_read_ff <= s1_read_ff;
         s2_inc_ff  <= !s1_read_ff;
         s2_addr_ff <= hist_rd_addr;
      end
   end

   // histogram ram with a valid bit per bin; unwritten bins read zero
   logic [COUNT_BITS-1:0]   hist_rd_data;
   logic [COUNT_BITS-1:0]   cur_count;
   logic [COUNT_BITS-1:0]   hist_wr_data;
   logic                    hist_wr_en;
   logic [lbp_pkg::BINS-1:0] bin_vld_ff;
   logic                    fwd_valid_ff;
   logic [BIN_AW-1:0]       fwd_addr_ff;
   logic [COUNT_BITS-1:0]   fwd_data_ff;

   lbp_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (lbp_pkg::BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (s2_addr_ff),
      .wr_data (hist_wr_data),
      .rd_en   (adv),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   // current count: forward the write made while this bin was being read
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s2_addr_ff)) begin
         cur_count = fwd_data_ff;
      end else if (bin_vld_ff[s2_addr_ff]) begin
         cur_count = hist_rd_data;
      end else begin
         cur_count = '0;
      end
      if (s2_read_ff) begin
         hist_wr_data = '0;
      end else if (cur_count == COUNT_MAX) begin
         hist_wr_data = cur_count;
      end else begin
         hist_wr_data = cur_count + COUNT_BITS'(1);
      end
      hist_wr_en = adv && s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_vld_ff   <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (adv) begin
         fwd_valid_ff <= hist_wr_en;
         if (hist_wr_en) begin
            bin_vld_ff[s2_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_addr_ff <= s2_addr_ff;
         fwd_data_ff <= hist_wr_data;
      end
   end

   // count as seen on the port, saturated to its width
   logic [lbp_pkg::OUT_CNT_W-1:0] out_count;

   generate
      if (COUNT_BITS > lbp_pkg::OUT_CNT_W) begin : g_wide
         assign out_count = (|cur_count[COUNT_BITS-1:lbp_pkg::OUT_CNT_W]) ?
                            {lbp_pkg::OUT_CNT_W{1'b1}} :
                            cur_count[lbp_pkg::OUT_CNT_W-1:0];
      end else begin : g_narrow
         assign out_count = lbp_pkg::OUT_CNT_W'(cur_count);
      end
   endgenerate

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   lbp_pkg::rsp_item_type rsp_item_ff;
   logic                  rsp_load;

   assign rsp_load = adv && s2_valid_ff && s2_read_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_item_ff.bin_index <= s2_addr_ff;
         rsp_item_ff.bin_count <= out_count;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // checks
   `LBP_ASSERT_IMP(a_no_stall_when_out_free, clock, reset, !rsp_valid_ff, !req_stall, "stall while output register free")
   `LBP_ASSERT_NEXT(a_rsp_from_read, clock, reset, !rsp_valid_ff && !rsp_load, !rsp_valid_ff, "result without a read item")
   `LBP_ASSERT_IMP(a_inc_never_wraps, clock, reset, hist_wr_en && s2_inc_ff, hist_wr_data != '0, "bin count wrapped to zero")
   `LBP_ASSERT_IMP(a_line_slot_apart, clock, reset, lb_wr_en && push_acc, col_ff != s1_col_ff, "line buffer read and write hit one column")

endmodule

`default_nettype wire

@@ rtl/core/lbp_ram.sv @@
// lbp_ram: generic single write, single read ram with registered read data
// depends on nothing; read returns the old word when read and write collide
`default_nettype none

module lbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, holds its data when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ tb/lbp_code_histogram_checker.sv @@
`timescale 1ns / 1ps
// lbp_code_histogram_checker: watches the req, rsp and csr ports of the lbp histogram,
// predicts every read result from its own pattern and histogram state and compares it
// depends on lbp_pkg only; instantiated by tb_lbp_code_histogram_top
module lbp_code_histogram_checker
   import lbp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire req_item_type          req_item,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire rsp_item_type          rsp_item,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         error_count,
   output int                         pending_reads,
   output int                         pushes_to_frame_end
);

   localparam int LINE_DEPTH = 2048;
   localparam int SIZE_CAP   = 2048;

   // predicted block state
   logic [CSR_DATA_W-1:0] width_cfg;
   logic [CSR_DATA_W-1:0] height_cfg;
   logic [PIX_W-1:0]      line_above     [LINE_DEPTH];
   logic [PIX_W-1:0]      line_two_above [LINE_DEPTH];
   logic [PIX_W-1:0]      pix_win        [3][3];
   int unsigned           col_pos;
   int unsigned           row_pos;
   logic [OUT_CNT_W-1:0]  code_bins      [BINS];

   // read results still to come, oldest first
   rsp_item_type expected_reads [$];
   int           fails = 0;

   function automatic int unsigned clamp_size(input logic [CSR_DATA_W-1:0] v);
      if (v < 3) return 3;
      if (v > SIZE_CAP) return SIZE_CAP;
      return v;
   endfunction

   // neighbour bits clockwise from the top-left corner
   function automatic logic [CODE_W-1:0] window_pattern();
      logic [PIX_W-1:0]  ctr;
      logic [CODE_W-1:0] code;
      ctr     = pix_win[1][1];
      code[0] = pix_win[0][0] >= ctr;
      code[1] = pix_win[0][1] >= ctr;
      code[2] = pix_win[0][2] >= ctr;
      code[3] = pix_win[1][2] >= ctr;
      code[4] = pix_win[2][2] >= ctr;
      code[5] = pix_win[2][1] >= ctr;
      code[6] = pix_win[2][0] >= ctr;
      code[7] = pix_win[1][0] >= ctr;
      return code;
   endfunction

   // shift the window, update the line buffers and count interior codes
   function automatic void take_pixel(input logic [PIX_W-1:0] px);
      int unsigned       w;
      int unsigned       h;
      logic [PIX_W-1:0]  top_px;
      logic [PIX_W-1:0]  mid_px;
      logic [CODE_W-1:0] code;
      w      = clamp_size(width_cfg);
      h      = clamp_size(height_cfg);
      top_px = line_two_above[col_pos];
      mid_px = line_above[col_pos];
      for (int r = 0; r < 3; r++) begin
         pix_win[r][0] = pix_win[r][1];
         pix_win[r][1] = pix_win[r][2];
      end
      pix_win[0][2]           = top_px;
      pix_win[1][2]           = mid_px;
      pix_win[2][2]           = px;
      line_two_above[col_pos] = mid_px;
      line_above[col_pos]     = px;
      if (row_pos >= 2 && col_pos >= 2) begin
         code = window_pattern();
         // counters stick at all ones
         if (code_bins[code] != '1) begin
            code_bins[code] = code_bins[code] + 1'b1;
         end
      end
      // row and frame wrap, sizes take effect at once
      if (col_pos >= w - 1) begin
         col_pos = 0;
         if (row_pos >= h - 1) begin
            row_pos = 0;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   // pushes left until row and column are both back at zero
   function automatic int frame_remaining();
      int unsigned w;
      int unsigned h;
      int unsigned rows_left;
      int unsigned cols_left;
      if (row_pos == 0 && col_pos == 0) return 0;
      w         = clamp_size(width_cfg);
      h         = clamp_size(height_cfg);
      rows_left = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
      cols_left = (col_pos >= w - 1) ? 1 : w - col_pos;
      return rows_left * w + cols_left;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type      want;
      logic [CODE_W-1:0] sel;
      if (reset) begin
         width_cfg  = WIDTH_RESET;
         height_cfg = HEIGHT_RESET;
         col_pos    = 0;
         row_pos    = 0;
         for (int i = 0; i < LINE_DEPTH; i++) begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
         end
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               pix_win[r][c] = '0;
            end
         end
         for (int b = 0; b < BINS; b++) begin
            code_bins[b] = '0;
         end
         expected_reads.delete();
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               REG_IMAGE_WIDTH: begin
                  width_cfg = csr_data;
               end
               REG_IMAGE_HEIGHT: begin
                  height_cfg = csr_data;
               end
               default: begin
               end
            endcase
         end
         // compare each result item with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_reads.size() == 0) begin
               fails++;
               $error("rsp item with no read outstanding: bin_index %0d bin_count %0d",
                      rsp_item.bin_index, rsp_item.bin_count);
            end else begin
               want = expected_reads.pop_front();
               if (rsp_item.bin_index !== want.bin_index) begin
                  fails++;
                  $error("bin_index: expected %0d, got %0d",
                         want.bin_index, rsp_item.bin_index);
               end
               if (rsp_item.bin_count !== want.bin_count) begin
                  fails++;
                  $error("bin_count: expected %0d, got %0d",
                         want.bin_count, rsp_item.bin_count);
               end
            end
         end
         // accepted request items
         if (req_valid && !req_stall) begin
            if (req_item.operation == OP_READ) begin
               sel            = req_item.bin_select;
               want.bin_index = sel;
               want.bin_count = code_bins[sel];
               expected_reads.push_back(want);
               code_bins[sel] = '0;
            end else begin
               take_pixel(req_item.pixel);
            end
         end
      end
      pending_reads       <= expected_reads.size();
      pushes_to_frame_end <= frame_remaining();
      error_count         <= fails;
   end

endmodule

@@ tb/tb_lbp_code_histogram_top.sv @@
`timescale 1ns / 1ps
// tb_lbp_code_histogram_top: clock, reset, stimulus and verdict for the lbp histogram
// depends on lbp_pkg, lbp_code_histogram_top and lbp_code_histogram_checker
module tb_lbp_code_histogram_top;
   import lbp_pkg::*;

   localparam int RANDOM_ITEMS  = 360;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 4000000;
   localparam int FULL_SIZE     = 2048;
   localparam int WIDE_PUSHES   = 100;
   localparam int TALL_PUSHES   = 120;

   typedef enum int {PIX_FULL, PIX_BAND, PIX_RAILS} pixel_style_e;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_item_type          req_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_item_type          rsp_item;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int           error_count;
   int           pending_reads;
   int           pushes_to_frame_end;
   bit           quiet      = 1'b0;
   int           stall_left = 0;
   int           items_sent = 0;
   int           cur_width;
   int           band_base;
   pixel_style_e pix_style;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   lbp_code_histogram_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   lbp_code_histogram_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_item            (req_item),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_item            (rsp_item),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .error_count         (error_count),
      .pending_reads       (pending_reads),
      .pushes_to_frame_end (pushes_to_frame_end)
   );

   // mostly short idle stretches, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic int pick_gap();
      if (quiet || $urandom_range(0, 99) < 55) return 0;
      return idle_len();
   endfunction

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return $urandom_range(0, 2);
      if (r < 80) return $urandom_range(3, 8);
      if (r < 96) return $urandom_range(9, 20);
      return $urandom_range(21, 40);
   endfunction

   function automatic int eff_size(input int v);
      if (v < 3) return 3;
      if (v > FULL_SIZE) return FULL_SIZE;
      return v;
   endfunction

   // a narrow band gives many equal neighbours and so a wide spread of codes
   function automatic logic [PIX_W-1:0] pick_pixel();
      case (pix_style)
         PIX_BAND: begin
            return PIX_W'(band_base + $urandom_range(0, 2));
         end
         PIX_RAILS: begin
            return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
         end
         default: begin
            return PIX_W'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // flat areas land in the all-ones bin, so read it often
   function automatic logic [CODE_W-1:0] pick_bin();
      if ($urandom_range(0, 99) < 30) return 8'hFF;
      return CODE_W'($urandom_range(0, 255));
   endfunction

   // random result-side stall
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
         rsp_stall  <= 1'b1;
         stall_left <= idle_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // one item on req, returns at the edge where it is taken
   task automatic send_item(input logic op, input logic [PIX_W-1:0] px,
                            input logic [CODE_W-1:0] sel);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_item.operation  <= op;
      req_item.pixel      <= px;
      req_item.bin_select <= sel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // a fixed number of pixel pushes with reads mixed in
   task automatic push_run(input int pushes, input int read_pct);
      int done;
      done = 0;
      while (done < pushes) begin
         if ($urandom_range(0, 99) < read_pct) begin
            send_item(OP_READ, PIX_W'($urandom_range(0, 255)), pick_bin());
         end else begin
            send_item(OP_PUSH, pick_pixel(), CODE_W'($urandom_range(0, 255)));
            done++;
         end
      end
   endtask

   task automatic read_all_bins();
      for (int b = 0; b < BINS; b++) begin
         send_item(OP_READ, PIX_W'($urandom_range(0, 255)), CODE_W'(b));
      end
   endtask

   // hold off until every read result is back and the pipeline has drained
   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reads != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic reconfigure(input bit do_w, input bit do_h, input int w, input int h);
      int n;
      go_idle();
      // a wider row would read line-buffer columns not yet written in this frame
      if (do_w && eff_size(w) > cur_width && pushes_to_frame_end != 0) begin
         n = pushes_to_frame_end;
         push_run(n, 0);
         go_idle();
      end
      if (do_w) begin
         csr_write <= 1'b1;
         csr_index <= REG_IMAGE_WIDTH;
         csr_data  <= CSR_DATA_W'(w);
         @(posedge clock);
         cur_width = eff_size(w);
      end
      if (do_h) begin
         csr_write <= 1'b1;
         csr_index <= REG_IMAGE_HEIGHT;
         csr_data  <= CSR_DATA_W'(h);
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // cycle counter against a hang
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int cfg_pick;
      int random_start;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      rsp_stall <= 1'b0;
      csr_write <= 1'b0;
      csr_index <= REG_IMAGE_WIDTH;
      csr_data  <= '0;
      cur_width = WIDTH_RESET;
      band_base = 0;
      pix_style = PIX_FULL;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // bins straight after reset hold zero
      send_item(OP_READ, 8'd0, 8'd0);
      send_item(OP_READ, 8'd255, 8'd255);
      // sizes below the minimum clamp to 3x3
      reconfigure(1'b1, 1'b1, 0, 1);
      // flat frame of zeros: every neighbour equals the centre
      repeat (9) send_item(OP_PUSH, 8'd0, 8'd255);
      // bright centre that only the top-left corner matches, with a read mid-frame
      send_item(OP_PUSH, 8'd255, 8'd0);
      send_item(OP_PUSH, 8'd0, 8'd0);
      send_item(OP_PUSH, 8'd0, 8'd0);
      send_item(OP_PUSH, 8'd0, 8'd0);
      send_item(OP_READ, 8'd0, 8'd255);
      send_item(OP_PUSH, 8'd255, 8'd0);
      repeat (4) send_item(OP_PUSH, 8'd0, 8'd0);
      send_item(OP_READ, 8'd0, 8'd1);
      // a read clears its bin
      send_item(OP_READ, 8'd0, 8'd255);

      // width above the cap: a long first row, cut short by the narrower row after it
      pix_style = PIX_BAND;
      band_base = $urandom_range(0, 253);
      reconfigure(1'b1, 1'b1, 4095, 3);
      push_run(WIDE_PUSHES, 2);
      // height above the cap: many narrow rows, then a short height ends the frame
      pix_style = PIX_FULL;
      reconfigure(1'b1, 1'b1, 3, 4095);
      push_run(TALL_PUSHES, 5);
      reconfigure(1'b0, 1'b1, 0, 3);
      read_all_bins();

      // random phases, sizes changed between them, often mid-frame
      random_start = items_sent;
      while (items_sent < random_start + RANDOM_ITEMS) begin
         quiet     <= ($urandom_range(0, 5) == 0);
         pix_style = pixel_style_e'($urandom_range(0, 2));
         band_base = $urandom_range(0, 253);
         cfg_pick  = $urandom_range(0, 3);
         reconfigure(cfg_pick[0], cfg_pick[1], pick_size(), pick_size());
         push_run($urandom_range(8, 60), ($urandom_range(0, 1) != 0) ? 12 : 35);
      end
      quiet <= 1'b0;
      read_all_bins();
      go_idle();

      if (error_count == 0 && pending_reads == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lbp_pkg.sv
rtl/core/lbp_ram.sv
rtl/core/lbp_code_histogram_top.sv
tb/lbp_code_histogram_checker.sv
tb/tb_lbp_code_histogram_top.sv
